/* sv/fqrr_pkg.sv */
// Shared types and constants for the ordered queue with key removal and cursor.
// Used by fqrr_cell and fifo_queue_remove_match_round_robin_top. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fqrr_pkg;

  // Fixed port widths
  localparam int unsigned DATA_W   = 32;  // data_in, data_out
  localparam int unsigned MASK_W   = 32;  // match mask register
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MODE_W   = 3;

  // Parameter defaults
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ENTRY_WIDTH = 32;

  // Mask value after reset
  localparam logic [MASK_W-1:0] MASK_RESET = '1;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ    = 3'd0,
    MODE_DEQ    = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_PEEK   = 3'd3,
    MODE_BEGIN  = 3'd4,
    MODE_NEXT   = 3'd5,
    MODE_EXISTS = 3'd6,
    MODE_NOP    = 3'd7
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // Control FSM
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_e;

  // Commands broadcast along the row of cells
  typedef struct packed {
    logic cmp;    // latch key compare result
    logic push;   // cell at the tail loads the new entry
    logic shift;  // cells from the first marked one (every cell on a dequeue) take the neighbor's entry
  } cell_ctrl_t;

endpackage : fqrr_pkg

`default_nettype wire

/* sv/fqrr_cell.sv */
// One storage cell of the queue row: holds an entry and its key-compare flag.
// Depends on fqrr_pkg for the cell command struct.
`timescale 1ns / 1ps
`default_nettype none

module fqrr_cell #(
  parameter int unsigned ENTRY_WIDTH = 32,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned CELL_IDX    = 0
) (
  input  wire                          clk_i,
  input  wire fqrr_pkg::cell_ctrl_t    ctrl_i,
  input  wire  [CNT_W-1:0]             count_i,
  input  wire  [ENTRY_WIDTH-1:0]       key_i,
  input  wire  [ENTRY_WIDTH-1:0]       mask_i,
  input  wire  [ENTRY_WIDTH-1:0]       push_data_i,
  input  wire  [ENTRY_WIDTH-1:0]       nbr_entry_i,
  input  wire                          found_i,
  output logic [ENTRY_WIDTH-1:0]       entry_o,
  output logic                         match_o,
  output logic                         found_o
);
  import fqrr_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  logic [ENTRY_WIDTH-1:0] entry_q;
  logic                   match_q;
  logic                   held;
  logic                   hit;

  // Compare only while this cell holds a live entry
  assign held = (MY_IDX < count_i);
  assign hit  = held && (((entry_q ^ key_i) & mask_i) == '0);

  // Latch compare flag when a transfer is taken
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      match_q <= hit;
    end
  end

  // Load at the tail, or take the neighbor's entry to close a gap
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (MY_IDX == count_i)) begin
      entry_q <= push_data_i;
    end else if (ctrl_i.shift && (found_i || match_q)) begin
      entry_q <= nbr_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign found_o = found_i || match_q;

endmodule : fqrr_cell

`default_nettype wire

/* sv/fifo_queue_remove_match_round_robin_top.sv */
// Top level of the ordered queue with remove-by-key and round-robin cursor.
// Depends on fqrr_pkg and instantiates a row of fqrr_cell.
//
//   channel   ports                                        direction  handshake
//   command   start, busy, mode_i, data_in_i               in         start && !busy
//   result    done_o, status_o, data_out_o, entry_count_o,  out        done_o (one cycle)
//             cursor_looped_o, cursor_active_o
//   config    cfg_we_i, match_mask_i                        in         cfg_we_i
//
// Each command has an accept step and a commit step: on accept each cell latches
// its key compare and the FSM enters ST_APPLY; in ST_APPLY the operation commits
// (shift, load, cursor) and the result is registered; done_o is high in the cycle after,
// when busy is already low, so a new command can be taken while done_o is high.
// Reset clears the count, cursor and FSM at once; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_remove_match_round_robin_top #(
  parameter int unsigned QUEUE_DEPTH = fqrr_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ENTRY_WIDTH = fqrr_pkg::DEF_ENTRY_WIDTH,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire  [fqrr_pkg::MODE_W-1:0]      mode_i,
  input  wire  [fqrr_pkg::DATA_W-1:0]      data_in_i,
  output logic                             done_o,
  output logic [fqrr_pkg::STATUS_W-1:0]    status_o,
  output logic [fqrr_pkg::DATA_W-1:0]      data_out_o,
  output logic [CNT_W-1:0]                 entry_count_o,
  output logic                             cursor_looped_o,
  output logic                             cursor_active_o,
  input  wire                              cfg_we_i,
  input  wire  [fqrr_pkg::MASK_W-1:0]      match_mask_i
);
  import fqrr_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Control and architectural state
  state_e               state_q, state_d;
  mode_e                mode_q;
  logic [DATA_W-1:0]    data_q;
  logic [MASK_W-1:0]    mask_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [PTR_W-1:0]     cpos_q, cpos_d;
  logic                 cset_q, cset_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [DATA_W-1:0]    dout_q, dout_d;
  logic                 done_q, done_d;

  logic                 accept;
  logic                 apply;
  cell_ctrl_t           ctrl;

  // Row wiring
  logic [ENTRY_WIDTH-1:0] entry_w [QUEUE_DEPTH];
  logic [ENTRY_WIDTH-1:0] nbr_w   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match_w;
  logic [QUEUE_DEPTH:0]   found_w;

  // Width adaption between fixed ports and the entry width
  logic [ENTRY_WIDTH-1:0] key_in_e;
  logic [ENTRY_WIDTH-1:0] push_e;
  logic [ENTRY_WIDTH-1:0] mask_e;
  logic [ENTRY_WIDTH-1:0] rd_e;
  logic [DATA_W-1:0]      rd_d;

  assign key_in_e = ENTRY_WIDTH'(data_in_i);
  assign push_e   = ENTRY_WIDTH'(data_q);
  assign mask_e   = ENTRY_WIDTH'(mask_q);

  // Handshake
  assign accept = start && !busy;
  assign apply  = (state_q == ST_APPLY);

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_APPLY;
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    unique case (state_q)
      ST_IDLE:  busy = 1'b0;
      ST_APPLY: busy = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  // Row of cells; cell i takes its neighbor's entry on a shift
  assign found_w[0] = (mode_q == MODE_DEQ);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign nbr_w[gi] = '0;
      end else begin : g_mid
        assign nbr_w[gi] = entry_w[gi+1];
      end
      fqrr_cell #(
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .CNT_W       (CNT_W),
        .CELL_IDX    (gi)
      ) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .count_i     (count_q),
        .key_i       (key_in_e),
        .mask_i      (mask_e),
        .push_data_i (push_e),
        .nbr_entry_i (nbr_w[gi]),
        .found_i     (found_w[gi]),
        .entry_o     (entry_w[gi]),
        .match_o     (match_w[gi]),
        .found_o     (found_w[gi+1])
      );
    end
  endgenerate

  // Operation decode and commit values
  always_comb begin
    logic             empty;
    logic             full;
    logic             any_hit;
    logic [PTR_W-1:0] first;
    logic             del;
    logic [PTR_W-1:0] del_idx;
    logic [CNT_W-1:0] n1;
    logic [PTR_W-1:0] pe;
    logic [CNT_W-1:0] pe_inc;
    logic [CNT_W-1:0] k_inc;

    empty     = (count_q == '0);
    full      = (count_q >= FULL_CNT);
    any_hit   = |match_w;
    first     = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (match_w[i]) first = PTR_W'(i);
    end
    del       = 1'b0;
    del_idx   = '0;
    n1        = count_q - CNT_W'(1);
    pe        = (CNT_W'(cpos_q) >= count_q) ? '0 : cpos_q;
    pe_inc    = CNT_W'(pe) + CNT_W'(1);
    k_inc     = CNT_W'(first) + CNT_W'(1);

    // Select the entry to read: the one under the cursor, or the head
    rd_e      = (mode_q == MODE_NEXT) ? entry_w[pe] : entry_w[0];
    rd_d      = DATA_W'(rd_e);

    ctrl      = '{cmp: accept, push: 1'b0, shift: 1'b0};
    count_d   = count_q;
    cpos_d    = cpos_q;
    cset_d    = cset_q;
    status_d  = STATUS_MISS;
    dout_d    = '0;
    done_d    = apply;

    if (apply) begin
      unique case (mode_q)
        MODE_ENQ: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ctrl.push = 1'b1;
            count_d   = count_q + CNT_W'(1);
            status_d  = STATUS_OK;
          end
        end
        MODE_DEQ: begin
          if (!empty) begin
            dout_d   = rd_d;
            del      = 1'b1;
            del_idx  = '0;
            status_d = STATUS_OK;
          end
        end
        MODE_REMOVE: begin
          if (any_hit) begin
            del      = 1'b1;
            del_idx  = first;
            status_d = STATUS_OK;
          end
        end
        MODE_PEEK: begin
          if (!empty) begin
            dout_d   = rd_d;
            status_d = STATUS_OK;
          end
        end
        MODE_BEGIN: begin
          if (!empty) begin
            cset_d   = 1'b1;
            cpos_d   = '0;
            status_d = STATUS_OK;
          end
        end
        MODE_NEXT: begin
          if (cset_q && !empty) begin
            dout_d    = rd_d;
            cpos_d    = (pe_inc < count_q) ? pe_inc[PTR_W-1:0] : '0;
            status_d  = STATUS_OK;
          end
        end
        MODE_EXISTS: begin
          if (!empty) begin
            cset_d = 1'b1;
            if (any_hit) begin
              cpos_d   = (k_inc < count_q) ? k_inc[PTR_W-1:0] : '0;
              status_d = STATUS_OK;
            end else begin
              cpos_d   = '0;
            end
          end
        end
        default: begin
          status_d = STATUS_MISS;
        end
      endcase
    end

    // Drop an entry, close the gap and fix the cursor
    if (del) begin
      ctrl.shift = 1'b1;
      count_d    = n1;
      if (cset_q) begin
        if (cpos_q > del_idx) begin
          cpos_d = cpos_q - PTR_W'(1);
        end else if ((cpos_q == del_idx) && (CNT_W'(del_idx) >= n1)) begin
          cset_d = 1'b0;
        end
      end
      if (n1 == '0) cset_d = 1'b0;
      if (!cset_d) cpos_d = '0;
    end
  end

  // Hold the command for the commit cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      data_q <= data_in_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    dout_q   <= dout_d;
  end

  // Control state, counters and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      cpos_q  <= '0;
      cset_q  <= 1'b0;
      done_q  <= 1'b0;
      mask_q  <= MASK_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cpos_q  <= cpos_d;
      cset_q  <= cset_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        mask_q <= match_mask_i;
      end
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign data_out_o      = dout_q;
  assign entry_count_o   = count_q;
  assign cursor_active_o = cset_q;
  assign cursor_looped_o = cset_q && (cpos_q == '0);

endmodule : fifo_queue_remove_match_round_robin_top

`default_nettype wire
